### rtl/core/tlbpt_pkg.sv
// shared constants, types and state codes for the tlb probe and translate block
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 32;
    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

    localparam logic [31:0] VPN2_MASK    = 32'hFFFF_E000;
    localparam logic [7:0]  ASID_ZERO    = 8'h00;
    localparam logic [24:0] PMASK_BITS   = 25'h1FF_E000;
    localparam logic [31:0] LO_PFN_MASK  = 32'h3FFF_FFC0;
    localparam int          LO_PFN_SHIFT = 6;
    localparam int          LO_VALID_BIT = 1;
    localparam logic [31:0] HALF_STEP    = 32'h0000_2000;
    localparam logic [31:0] PHYS_MISS    = 32'hFFFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic        op;
        logic [4:0]  entry_index;
        logic [31:0] entry_hi_word;
        logic [24:0] entry_page_mask;
        logic [31:0] entry_lo_even;
        logic [31:0] entry_lo_odd;
        logic        entry_global;
        logic [31:0] probe_vaddr;
        logic [7:0]  current_asid;
    } item_t;

    typedef struct packed {
        logic [31:0] phys_addr;
        logic        entry_matched;
        logic        page_valid;
    } result_t;

    typedef struct packed {
        logic [31:0] hi;
        logic [24:0] mask;
        logic [31:0] lo_even;
        logic [31:0] lo_odd;
        logic        global_bit;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic [31:0] vaddr;
        logic [7:0]  asid;
    } probe_t;

    typedef struct packed {
        logic        hit;
        logic        valid;
        logic [31:0] phys;
    } hit_t;

endpackage

### rtl/core/tlbpt_store.sv
// tlb entry memory with per-entry valid bits and registered read port
module tlbpt_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlbpt_pkg::wr_req_t wr,
    input  tlbpt_pkg::rd_req_t rd,
    output tlbpt_pkg::entry_t  entry
);

    tlbpt_pkg::entry_t                       mem [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_ENTRIES-1:0]       vld_reg;
    tlbpt_pkg::entry_t                       rd_data_reg;
    logic                                    rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_ok_reg <= vld_reg[rd.addr];
            end
        end
    end

    // an entry never written reads as all zeros
    assign entry = rd_ok_reg ? rd_data_reg : '0;

endmodule

### rtl/core/tlbpt_match.sv
// shared compare and translate unit, evaluates one tlb entry per cycle
module tlbpt_match
(
    input  tlbpt_pkg::entry_t entry,
    input  tlbpt_pkg::probe_t probe,
    output tlbpt_pkg::hit_t   res
);

    logic [31:0] mask_w;
    logic [31:0] cmp;
    logic [31:0] sel;
    logic [31:0] lo;
    logic [31:0] base;
    logic        vpn_eq;
    logic        asid_ok;

    always_comb
    begin
        mask_w  = {7'b0, entry.mask};
        cmp     = tlbpt_pkg::VPN2_MASK & ~mask_w;
        vpn_eq  = ((entry.hi ^ probe.vaddr) & cmp) == '0;
        asid_ok = entry.global_bit || ((entry.hi[7:0] ^ probe.asid) == tlbpt_pkg::ASID_ZERO);
        sel     = (mask_w + tlbpt_pkg::HALF_STEP) >> 1;
        lo      = ((probe.vaddr & sel) == '0) ? entry.lo_even : entry.lo_odd;
        base    = (lo & tlbpt_pkg::LO_PFN_MASK) << tlbpt_pkg::LO_PFN_SHIFT;

        res.hit   = vpn_eq && asid_ok;
        res.valid = lo[tlbpt_pkg::LO_VALID_BIT];
        res.phys  = base + ((sel - 32'd1) & probe.vaddr);
    end

endmodule

### rtl/core/tlbpt_ctrl.sv
// sequencer: entry writes, serial probe scan and result beat
module tlbpt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tlbpt_pkg::item_t    item,
    input  tlbpt_pkg::hit_t     mres,
    output logic                busy,
    output logic                done,
    output tlbpt_pkg::result_t  result,
    output tlbpt_pkg::wr_req_t  wr,
    output tlbpt_pkg::rd_req_t  rd,
    output tlbpt_pkg::probe_t   probe
);

    tlbpt_pkg::state_t               state_reg, state_next;
    logic [tlbpt_pkg::CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic                            rd_last_reg, rd_last_next;
    tlbpt_pkg::probe_t               probe_reg, probe_next;
    tlbpt_pkg::result_t              res_reg, res_next;
    tlbpt_pkg::result_t              miss_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tlbpt_pkg::ST_IDLE;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        miss_res.phys_addr     = tlbpt_pkg::PHYS_MISS;
        miss_res.entry_matched = 1'b0;
        miss_res.page_valid    = 1'b0;

        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        rd_pend_next = rd_pend_reg;
        rd_last_next = rd_last_reg;
        probe_next   = probe_reg;
        res_next     = res_reg;

        wr.en              = 1'b0;
        wr.addr            = tlbpt_pkg::IDX_W'(item.entry_index);
        wr.data.hi         = item.entry_hi_word;
        wr.data.mask       = item.entry_page_mask & tlbpt_pkg::PMASK_BITS;
        wr.data.lo_even    = item.entry_lo_even;
        wr.data.lo_odd     = item.entry_lo_odd;
        wr.data.global_bit = item.entry_global;

        rd.en   = 1'b0;
        rd.addr = rd_cnt_reg[tlbpt_pkg::IDX_W-1:0];

        unique case (state_reg)
            tlbpt_pkg::ST_IDLE:
            begin
                rd_pend_next = 1'b0;
                if (start)
                begin
                    if (item.op == tlbpt_pkg::OP_WRITE)
                    begin
                        wr.en      = 32'(item.entry_index) < 32'(tlbpt_pkg::TLB_ENTRIES);
                        res_next   = miss_res;
                        state_next = tlbpt_pkg::ST_RESP;
                    end
                    else
                    begin
                        probe_next.vaddr = item.probe_vaddr;
                        probe_next.asid  = item.current_asid;
                        rd_cnt_next      = '0;
                        state_next       = tlbpt_pkg::ST_SCAN;
                    end
                end
            end
            tlbpt_pkg::ST_SCAN:
            begin
                // read of the next entry overlaps the compare of the previous one
                if (rd_cnt_reg < tlbpt_pkg::CNT_W'(tlbpt_pkg::TLB_ENTRIES))
                begin
                    rd.en        = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + tlbpt_pkg::CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_last_next = rd_cnt_reg == tlbpt_pkg::CNT_W'(tlbpt_pkg::TLB_ENTRIES - 1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg)
                begin
                    if (mres.hit)
                    begin
                        res_next.phys_addr     = mres.valid ? mres.phys : tlbpt_pkg::PHYS_MISS;
                        res_next.entry_matched = 1'b1;
                        res_next.page_valid    = mres.valid;
                        state_next             = tlbpt_pkg::ST_RESP;
                    end
                    else if (rd_last_reg)
                    begin
                        res_next   = miss_res;
                        state_next = tlbpt_pkg::ST_RESP;
                    end
                end
            end
            tlbpt_pkg::ST_RESP:
            begin
                rd_pend_next = 1'b0;
                state_next   = tlbpt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlbpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = state_reg != tlbpt_pkg::ST_IDLE;
    assign done   = state_reg == tlbpt_pkg::ST_RESP;
    assign result = res_reg;
    assign probe  = probe_reg;

endmodule

### rtl/core/tlb_probe_translate.sv
// top level of the 32-entry tlb with serial probe and address translation
//
//  channel   strobe / hold    payload
//  item      start / busy     item   (tlbpt_pkg::item_t)
//  result    done             result (tlbpt_pkg::result_t)
//
//  a write beat: entry stored at the accept edge, result beat in the next cycle
//  a probe beat: result beat after a scan that starts at entry 0 after the accept edge,
//  one entry per cycle through the single memory read port and the shared compare unit,
//  stopping at the first hit; the next beat can be accepted in the cycle after the result beat
//  busy is high from the cycle after accept until the result beat has gone
//  reset clears the state machine and the entry valid bits at once, no clearing pass
//  the result beat lasts exactly one cycle and cannot be held off
module tlb_probe_translate
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tlbpt_pkg::item_t   item,
    output logic               done,
    output tlbpt_pkg::result_t result
);

    tlbpt_pkg::wr_req_t wr;
    tlbpt_pkg::rd_req_t rd;
    tlbpt_pkg::entry_t  entry;
    tlbpt_pkg::probe_t  probe;
    tlbpt_pkg::hit_t    mres;

    tlbpt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .mres   (mres),
        .busy   (busy),
        .done   (done),
        .result (result),
        .wr     (wr),
        .rd     (rd),
        .probe  (probe)
    );

    tlbpt_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .entry (entry)
    );

    tlbpt_match u_match
    (
        .entry (entry),
        .probe (probe),
        .res   (mres)
    );

endmodule

### rtl/core/tlbpt_checker.sv
// port-level checks on the tlb probe and translate block, bound to the top level
module tlbpt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input tlbpt_pkg::item_t   item,
    input logic               done,
    input tlbpt_pkg::result_t result
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accept");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.op == tlbpt_pkg::OP_PROBE |=> !done)
        else $error("probe result too early");

    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.page_valid |-> result.phys_addr == tlbpt_pkg::PHYS_MISS)
        else $error("miss or invalid page without all-ones address");

endmodule

bind tlb_probe_translate tlbpt_checker u_tlbpt_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

### dv/tlb_probe_translate_tb.sv
// testbench for the tlb probe and translate block: directed table, then random beats
`timescale 1ns / 1ps

module tlb_probe_translate_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 420;

    typedef struct {
        tlbpt_pkg::item_t   it;
        logic               typed;
        tlbpt_pkg::result_t want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    tlbpt_pkg::item_t   item;
    logic               done;
    tlbpt_pkg::result_t result;

    logic [31:0] shadow_hi      [tlbpt_pkg::TLB_ENTRIES];
    logic [24:0] shadow_mask    [tlbpt_pkg::TLB_ENTRIES];
    logic [31:0] shadow_lo_even [tlbpt_pkg::TLB_ENTRIES];
    logic [31:0] shadow_lo_odd  [tlbpt_pkg::TLB_ENTRIES];
    logic        shadow_global  [tlbpt_pkg::TLB_ENTRIES];

    tlbpt_pkg::result_t pending_results[$];
    row_t               directed_rows[$];
    int                 mismatch_count;
    int                 idle_pct;
    int                 quiet_cycles;

    tlb_probe_translate u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tlbpt_pkg::result_t translate_item(tlbpt_pkg::item_t it);
        tlbpt_pkg::result_t r;
        logic [31:0]        mask32;
        logic [31:0]        cmp;
        logic [31:0]        sel;
        logic [31:0]        lo;
        logic [31:0]        base;
        logic               hit;
        r.phys_addr     = tlbpt_pkg::PHYS_MISS;
        r.entry_matched = 1'b0;
        r.page_valid    = 1'b0;
        hit             = 1'b0;
        if (it.op == tlbpt_pkg::OP_WRITE)
        begin
            if (int'(it.entry_index) < tlbpt_pkg::TLB_ENTRIES)
            begin
                shadow_hi[it.entry_index]      = it.entry_hi_word;
                shadow_mask[it.entry_index]    = it.entry_page_mask & tlbpt_pkg::PMASK_BITS;
                shadow_lo_even[it.entry_index] = it.entry_lo_even;
                shadow_lo_odd[it.entry_index]  = it.entry_lo_odd;
                shadow_global[it.entry_index]  = it.entry_global;
            end
        end
        else
        begin
            for (int k = 0; k < tlbpt_pkg::TLB_ENTRIES; k++)
            begin
                if (!hit)
                begin
                    mask32 = {7'd0, shadow_mask[k]};
                    cmp    = tlbpt_pkg::VPN2_MASK & ~mask32;
                    if (((shadow_hi[k] & cmp) == (it.probe_vaddr & cmp)) &&
                        (shadow_global[k] || shadow_hi[k][7:0] == it.current_asid))
                    begin
                        hit = 1'b1;
                        sel = (mask32 + tlbpt_pkg::HALF_STEP) >> 1;
                        lo  = ((it.probe_vaddr & sel) == 32'd0) ? shadow_lo_even[k]
                                                                : shadow_lo_odd[k];
                        r.entry_matched = 1'b1;
                        if (lo[tlbpt_pkg::LO_VALID_BIT])
                        begin
                            base         = (lo & tlbpt_pkg::LO_PFN_MASK)
                                           << tlbpt_pkg::LO_PFN_SHIFT;
                            r.page_valid = 1'b1;
                            r.phys_addr  = base + ((sel - 32'd1) & it.probe_vaddr);
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic tlbpt_pkg::item_t rand_item();
        tlbpt_pkg::item_t it;
        logic [31:0]      cmp;
        int               k;
        int               r;
        it.op              = tlbpt_pkg::OP_WRITE;
        it.entry_index     = 5'($urandom_range(31));
        it.entry_hi_word   = $urandom;
        if ($urandom_range(3) == 0)
            it.entry_hi_word[7:0] = 8'($urandom_range(3));
        case ($urandom_range(9))
            0: it.entry_page_mask = 25'h000_6000;
            1: it.entry_page_mask = 25'h001_E000;
            2: it.entry_page_mask = 25'h007_E000;
            3: it.entry_page_mask = 25'h01F_E000;
            4: it.entry_page_mask = 25'h07F_E000;
            5: it.entry_page_mask = 25'h1FF_E000;
            6, 7: it.entry_page_mask = 25'($urandom);
            default: it.entry_page_mask = 25'd0;
        endcase
        it.entry_lo_even   = $urandom;
        it.entry_lo_odd    = $urandom;
        it.entry_global    = 1'($urandom_range(1));
        it.probe_vaddr     = $urandom;
        it.current_asid    = 8'($urandom);
        r = $urandom_range(99);
        if (r >= 30)
        begin
            it.op = tlbpt_pkg::OP_PROBE;
            if (r < 85)
            begin
                k   = $urandom_range(tlbpt_pkg::TLB_ENTRIES - 1);
                cmp = tlbpt_pkg::VPN2_MASK & ~{7'd0, shadow_mask[k]};
                it.probe_vaddr = (shadow_hi[k] & cmp) | (it.probe_vaddr & ~cmp);
                if ($urandom_range(3) != 0)
                    it.current_asid = shadow_hi[k][7:0];
            end
            else if ($urandom_range(1) == 0)
                it.current_asid = 8'($urandom_range(3));
        end
        return it;
    endfunction

    function automatic void add_row(logic op, logic [4:0] idx, logic [31:0] hi,
                                    logic [24:0] mask, logic [31:0] lo_e, logic [31:0] lo_o,
                                    logic g, logic [31:0] va, logic [7:0] asid,
                                    logic typed, tlbpt_pkg::result_t want);
        row_t row;
        row.it.op              = op;
        row.it.entry_index     = idx;
        row.it.entry_hi_word   = hi;
        row.it.entry_page_mask = mask;
        row.it.entry_lo_even   = lo_e;
        row.it.entry_lo_odd    = lo_o;
        row.it.entry_global    = g;
        row.it.probe_vaddr     = va;
        row.it.current_asid    = asid;
        row.typed              = typed;
        row.want               = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_beat(tlbpt_pkg::item_t it, logic typed, tlbpt_pkg::result_t want);
        tlbpt_pkg::result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = translate_item(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        tlbpt_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", result.phys_addr,
                                tlbpt_pkg::PHYS_MISS);
            else
            begin
                want = pending_results.pop_front();
                if (result.phys_addr !== want.phys_addr)
                    report_mismatch("phys_addr", result.phys_addr, want.phys_addr);
                if (result.entry_matched !== want.entry_matched)
                    report_mismatch("entry_matched", 32'(result.entry_matched),
                                    32'(want.entry_matched));
                if (result.page_valid !== want.page_valid)
                    report_mismatch("page_valid", 32'(result.page_valid),
                                    32'(want.page_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        tlbpt_pkg::result_t none;
        tlbpt_pkg::result_t dead;
        none = {tlbpt_pkg::PHYS_MISS, 1'b0, 1'b0};
        dead = {tlbpt_pkg::PHYS_MISS, 1'b1, 1'b0};
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        idle_pct       = 18;
        for (int k = 0; k < tlbpt_pkg::TLB_ENTRIES; k++)
        begin
            shadow_hi[k]      = '0;
            shadow_mask[k]    = '0;
            shadow_lo_even[k] = '0;
            shadow_lo_odd[k]  = '0;
            shadow_global[k]  = 1'b0;
        end

        // cleared entries: zero address matches entry 0 with an invalid half
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_0000, 8'h00, 1'b1, dead);
        add_row(tlbpt_pkg::OP_PROBE, 5'd31, 32'hFFFF_FFFF, 25'h1FF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, none);
        add_row(tlbpt_pkg::OP_WRITE, 5'd0, 32'h0000_4005, 25'd0, 32'h0000_0042,
                32'h0000_0080, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_4123, 8'h05, 1'b0, none);
        // odd half not valid
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_5123, 8'h05, 1'b1, dead);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_4123, 8'h06, 1'b0, none);
        // mask bits outside the field dropped on store
        add_row(tlbpt_pkg::OP_WRITE, 5'd31, 32'hFFFF_FFFF, 25'h1FF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFD, 1'b1, 32'd0, 8'd0, 1'b1, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'hFFFF_FFFF, 8'h00, 1'b0, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'hFE00_0000, 8'h33, 1'b0, none);
        // translated address wraps
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'hFEFF_FFFF, 8'h33, 1'b0, none);
        // non-contiguous page mask
        add_row(tlbpt_pkg::OP_WRITE, 5'd1, 32'h0000_A0FF, 25'h000_A000, 32'h0000_0FC2,
                32'h0000_1002, 1'b0, 32'd0, 8'd0, 1'b1, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_A123, 8'hFF, 1'b0, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_8001, 8'hFF, 1'b0, none);
        // lowest entry wins, global entry ignores the asid
        add_row(tlbpt_pkg::OP_WRITE, 5'd2, 32'h0000_4000, 25'd0, 32'h3FFF_FFC2,
                32'h0000_0002, 1'b1, 32'd0, 8'd0, 1'b1, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_4000, 8'h05, 1'b0, none);
        add_row(tlbpt_pkg::OP_PROBE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'h0000_4FFF, 8'h09, 1'b0, none);
        add_row(tlbpt_pkg::OP_WRITE, 5'd0, 32'd0, 25'd0, 32'd0, 32'd0, 1'b0,
                32'd0, 8'd0, 1'b1, none);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 18 : ((phase == 1) ? 61 : 0);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_beat(rand_item(), 1'b0, none);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
